// ----- rtl/dlkm_pkg.sv -----
// Shared types, constants and LFSR step functions for the dual LFSR keystream masker.
package dlkm_pkg;

	localparam int DATA_W     = 64;
	localparam int CNT_W      = 4;
	localparam int NUM_BYTES  = 8;
	localparam int A_W        = 15;
	localparam int B_HI_W     = 64;
	localparam int B_LO_W     = 42;
	localparam int B_W        = B_HI_W + B_LO_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// Feedback taps: A uses a14 ^ a3, B uses b41 ^ b56 over the joined 106-bit word.
	localparam int TAP_A_HI = 14;
	localparam int TAP_A_LO = 3;
	localparam int TAP_B_LO = 41;
	localparam int TAP_B_HI = B_LO_W + 14;

	localparam logic [A_W-1:0]    SEED_A_RST    = 15'h5B5D;
	localparam logic [B_HI_W-1:0] SEED_B_HI_RST = 64'h0000_02D9_52AA_AAAA;
	localparam logic [B_LO_W-1:0] SEED_B_LO_RST = 42'h000_0036_D6AA;

	localparam logic [CNT_W-1:0] FULL_COUNT = 4'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEED_A      = 2'd0,
		CFG_SEED_B_HIGH = 2'd1,
		CFG_SEED_B_LOW  = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		KIND_MASK   = 1'b0,
		KIND_RELOAD = 1'b1
	} kind_t;

	typedef struct packed {
		logic advance;
		logic reload;
	} ks_ctrl_t;

	typedef struct packed {
		logic [A_W-1:0] a;
		logic [B_W-1:0] b;
	} lfsr_state_t;

	function automatic logic key_bit(lfsr_state_t s);
		key_bit = s.a[TAP_A_HI] ^ s.a[TAP_A_LO] ^ s.b[TAP_B_LO] ^ s.b[TAP_B_HI];
	endfunction

	function automatic lfsr_state_t lfsr_step(lfsr_state_t s);
		lfsr_state_t r;
		r.a = {s.a[A_W-2:0], s.a[TAP_A_HI] ^ s.a[TAP_A_LO]};
		r.b = {s.b[B_W-2:0], s.b[TAP_B_LO] ^ s.b[TAP_B_HI]};
		lfsr_step = r;
	endfunction

	// Clamp counts above a full word to eight bytes.
	function automatic logic [CNT_W-1:0] sat_count(logic [CNT_W-1:0] cnt);
		sat_count = (cnt > FULL_COUNT) ? FULL_COUNT : cnt;
	endfunction

	function automatic logic [DATA_W-1:0] byte_keep(logic [CNT_W-1:0] cnt);
		logic [DATA_W-1:0] k;
		k = '0;
		for (int j = 0; j < NUM_BYTES; j++) begin
			k[8*j +: 8] = {8{CNT_W'(j) < cnt}};
		end
		byte_keep = k;
	endfunction

endpackage

// ----- rtl/dlkm_in_if.sv -----
// Input channel: data words and reload commands.
interface dlkm_in_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [dlkm_pkg::DATA_W-1:0] data_block;
	logic [dlkm_pkg::CNT_W-1:0]  byte_count;

	modport source (output valid, kind, data_block, byte_count, input ready);
	modport sink   (input valid, kind, data_block, byte_count, output ready);
endinterface

// ----- rtl/dlkm_out_if.sv -----
// Output channel: masked data words.
interface dlkm_out_if;
	logic                        valid;
	logic                        ready;
	logic [dlkm_pkg::DATA_W-1:0] masked_block;
	logic [dlkm_pkg::CNT_W-1:0]  valid_bytes;

	modport source (output valid, masked_block, valid_bytes, input ready);
	modport sink   (input valid, masked_block, valid_bytes, output ready);
endinterface

// ----- rtl/dlkm_keystream.sv -----
// Keystream generator: both LFSRs, advanced a whole word per cycle while ctrl.advance is set.
module dlkm_keystream #(
	parameter int BLOCK_BITS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dlkm_pkg::ks_ctrl_t            ctrl,
	input  logic [dlkm_pkg::A_W-1:0]      seed_a,
	input  logic [dlkm_pkg::B_W-1:0]      seed_b,
	output logic [BLOCK_BITS-1:0]         keystream
);
	import dlkm_pkg::*;

	lfsr_state_t state_q;
	lfsr_state_t state_next;

	// Unrolled steps flatten into an XOR network over the state bits.
	always_comb begin
		lfsr_state_t walk;
		walk = state_q;
		for (int i = 0; i < BLOCK_BITS; i++) begin
			keystream[BLOCK_BITS-1-i] = key_bit(walk);
			walk = lfsr_step(walk);
		end
		state_next = walk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.a <= SEED_A_RST;
			state_q.b <= {SEED_B_HI_RST, SEED_B_LO_RST};
		end else if (ctrl.reload) begin
			state_q.a <= seed_a;
			state_q.b <= seed_b;
		end else if (ctrl.advance) begin
			state_q <= state_next;
		end
	end

endmodule

// ----- rtl/dual_lfsr_keystream_masker.sv -----
// Top level of the dual LFSR keystream masker.
//
//  channel  | dir | beat contents                         | accepted when
//  ---------+-----+---------------------------------------+------------------------
//  din      | in  | kind, data_block, byte_count          | din.valid & din.ready
//  dout     | out | masked_block, valid_bytes             | dout.valid & dout.ready
//  cfg      | in  | cfg_idx, cfg_wdata (seed registers)   | cfg_we
//
// One beat per cycle sustained while dout does not stall; a mask beat is captured in the input
// register when it is taken, then in the result register, from which dout offers it.
// The whole BLOCK_BITS-step LFSR advance is one XOR network between the state
// register and the result register.
// Reset loads seeds and LFSR state with their reset values and empties both stages.
// A reload beat passes the input register without using the result register.
// When dout stalls, hold the result and the input register; din.ready drops only then.
module dual_lfsr_keystream_masker #(
	parameter int BLOCK_BITS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	dlkm_in_if.sink                           din,
	dlkm_out_if.source                        dout,
	input  logic                              cfg_we,
	input  logic [dlkm_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [dlkm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import dlkm_pkg::*;

	// Seed registers
	logic [A_W-1:0]    seed_a_q;
	logic [B_HI_W-1:0] seed_b_hi_q;
	logic [B_LO_W-1:0] seed_b_lo_q;

	// Input stage
	logic              valid_s1;
	kind_t             kind_s1;
	logic [DATA_W-1:0] data_s1;
	logic [CNT_W-1:0]  cnt_s1;

	// Result register
	logic              out_valid_q;
	logic [DATA_W-1:0] masked_q;
	logic [CNT_W-1:0]  vbytes_q;

	logic                  adv_s1;
	logic                  take_in;
	ks_ctrl_t              ks_ctrl;
	logic [BLOCK_BITS-1:0] keystream;

	// Seed writes: index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_a_q    <= SEED_A_RST;
			seed_b_hi_q <= SEED_B_HI_RST;
			seed_b_lo_q <= SEED_B_LO_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_SEED_A:      seed_a_q    <= cfg_wdata[A_W-1:0];
				CFG_SEED_B_HIGH: seed_b_hi_q <= cfg_wdata[B_HI_W-1:0];
				CFG_SEED_B_LOW:  seed_b_lo_q <= cfg_wdata[B_LO_W-1:0];
				default: ;
			endcase
		end
	end

	// A reload never needs the result register; a mask beat needs it free or draining.
	assign adv_s1  = valid_s1 && ((kind_s1 == KIND_RELOAD) || !out_valid_q || dout.ready);
	assign din.ready = !valid_s1 || adv_s1;
	assign take_in = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the beat; saturate the count here so the next stage stays short.
	always_ff @(posedge clk) begin
		if (take_in) begin
			kind_s1 <= kind_t'(din.kind);
			data_s1 <= din.data_block;
			cnt_s1  <= sat_count(din.byte_count);
		end
	end

	assign ks_ctrl.advance = adv_s1 && (kind_s1 == KIND_MASK);
	assign ks_ctrl.reload  = adv_s1 && (kind_s1 == KIND_RELOAD);

	dlkm_keystream #(
		.BLOCK_BITS(BLOCK_BITS)
	) u_keystream (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ks_ctrl),
		.seed_a    (seed_a_q),
		.seed_b    ({seed_b_hi_q, seed_b_lo_q}),
		.keystream (keystream)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ks_ctrl.advance) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Mask the word and zero the bytes past the count.
	always_ff @(posedge clk) begin
		if (ks_ctrl.advance) begin
			masked_q <= (data_s1 ^ DATA_W'(keystream)) & byte_keep(cnt_s1);
			vbytes_q <= cnt_s1;
		end
	end

	assign dout.valid        = out_valid_q;
	assign dout.masked_block = masked_q;
	assign dout.valid_bytes  = vbytes_q;

	a_upper_bytes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((masked_q & ~byte_keep(vbytes_q)) == '0))
		else $error("masked bytes beyond valid_bytes are not zero");

	a_count_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (vbytes_q <= FULL_COUNT))
		else $error("valid_bytes above a full word");

	a_mask_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		ks_ctrl.advance |=> out_valid_q)
		else $error("mask beat left the input stage without a result");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(data_s1) && $stable(kind_s1)))
		else $error("input stage overwritten while stalled");

	a_ctrl_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ks_ctrl.advance && ks_ctrl.reload))
		else $error("keystream advance and reload in the same cycle");

endmodule
